// ===== hdl/integer_to_ascii_radix_assert.svh =====
// Assertion macros for the integer_to_ascii_radix checker.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define ITOA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define ITOA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/itoa_pkg.sv =====
// Shared types, constants and helpers for the integer-to-ASCII converter.
// No dependencies; used by every module of the block.
package itoa_pkg;

    // Operand and field widths
    localparam int ITOA_VALUE_WIDTH = 64;
    localparam int OP_W             = 2;
    localparam int VALUE_FIELD_W    = 64;
    localparam int BASE_W           = 5;
    localparam int DIGIT_W          = 4;
    localparam int CHAR_W           = 8;
    localparam int S_TDATA_W        = 72;
    localparam int VALUE_LSB        = OP_W;
    localparam int BASE_LSB         = OP_W + VALUE_FIELD_W;

    // Dividend bits consumed per cycle by the divider
    localparam int ITOA_CHUNK = 8;

    // Radix limits
    localparam logic [BASE_W-1:0] RADIX_MIN = 5'd2;
    localparam logic [BASE_W-1:0] RADIX_MAX = 5'd16;
    localparam logic [BASE_W-1:0] RADIX_DEC = 5'd10;

    // ASCII codes and digit offsets
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] LOWER_OFS  = 8'h57;
    localparam logic [CHAR_W-1:0] UPPER_OFS  = 8'h37;

    typedef enum logic [OP_W-1:0] {
        OP_SDEC,
        OP_UDEC,
        OP_RADIX_LOWER,
        OP_RADIX_UPPER
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef logic [DIGIT_W-1:0] t_digit;

    // Top level to emitter
    typedef struct packed {
        logic   push;
        logic   start;
        logic   negative;
        logic   upper;
        t_digit digit;
    } t_emit_ctrl;

    // Divider to top level
    typedef struct packed {
        logic   done;
        logic   qzero;
        t_digit digit;
    } t_div_stat;

    // Map a digit value to its ASCII character
    function automatic logic [CHAR_W-1:0] digit_char(input t_digit d, input logic upper);
        logic [CHAR_W-1:0] ext;
        ext = CHAR_W'(d);
        if (d < DIGIT_W'(RADIX_DEC)) begin
            return CHAR_ZERO + ext;
        end
        return (upper ? UPPER_OFS : LOWER_OFS) + ext;
    endfunction

endpackage

// ===== hdl/integer_to_ascii_radix.sv =====
// Integer to ASCII converter, radix 2..16, signed or unsigned decimal.
// The byte-serial divider makes one pass per digit; characters then leave at one beat per cycle
// while the output is ready. A new item is accepted only once every character of the last has left.
// Reset: synchronous, active low; clears control state, data registers keep their contents.
module integer_to_ascii_radix #(
    parameter int VALUE_WIDTH = itoa_pkg::ITOA_VALUE_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [1:0] opcode, [65:2] value, [70:66] base, [71] zero pad
    input  logic [itoa_pkg::S_TDATA_W-1:0]   i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [7:0] character
    output logic [itoa_pkg::CHAR_W-1:0]      o_m_tdata,
    output logic                             o_m_tlast
);

    localparam int BW = itoa_pkg::BASE_W;

    itoa_pkg::t_state      r_state;
    itoa_pkg::t_state      n_state;
    logic [BW-1:0]         r_radix;
    logic                  r_neg;
    logic                  r_upper;

    itoa_pkg::t_opcode     c_op;
    logic [VALUE_WIDTH-1:0] c_val;
    logic [VALUE_WIDTH-1:0] c_mag;
    logic [BW-1:0]         c_base;
    logic [BW-1:0]         c_radix;
    logic                  c_neg;
    logic                  c_accept;

    itoa_pkg::t_div_stat   div_stat;
    itoa_pkg::t_emit_ctrl  emit_ctrl;
    logic                  emit_busy;

    // Unpack the input beat, form the magnitude and the radix
    always_comb begin
        c_op   = itoa_pkg::t_opcode'(i_s_tdata[itoa_pkg::OP_W-1:0]);
        c_val  = i_s_tdata[itoa_pkg::VALUE_LSB +: VALUE_WIDTH];
        c_base = i_s_tdata[itoa_pkg::BASE_LSB +: BW];
        c_neg  = (c_op == itoa_pkg::OP_SDEC) && c_val[VALUE_WIDTH-1];
        c_mag  = c_neg ? (~c_val + 1'b1) : c_val;
        unique case (c_op) inside
            itoa_pkg::OP_SDEC, itoa_pkg::OP_UDEC: begin
                c_radix = itoa_pkg::RADIX_DEC;
            end
            itoa_pkg::OP_RADIX_LOWER, itoa_pkg::OP_RADIX_UPPER: begin
                if (c_base < itoa_pkg::RADIX_MIN) begin
                    c_radix = itoa_pkg::RADIX_MIN;
                end else if (c_base > itoa_pkg::RADIX_MAX) begin
                    c_radix = itoa_pkg::RADIX_MAX;
                end else begin
                    c_radix = c_base;
                end
            end
        endcase
    end

    assign c_accept   = i_s_tvalid && (r_state == itoa_pkg::ST_IDLE);
    assign o_s_tready = (r_state == itoa_pkg::ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and emitter control
    always_comb begin
        n_state            = r_state;
        emit_ctrl.push     = div_stat.done;
        emit_ctrl.start    = div_stat.done && div_stat.qzero;
        emit_ctrl.negative = r_neg;
        emit_ctrl.upper    = r_upper;
        emit_ctrl.digit    = div_stat.digit;
        unique case (r_state)
            itoa_pkg::ST_IDLE: begin
                if (c_accept) begin
                    n_state = itoa_pkg::ST_DIV;
                end
            end
            itoa_pkg::ST_DIV: begin
                if (div_stat.done && div_stat.qzero) begin
                    n_state = itoa_pkg::ST_EMIT;
                end
            end
            itoa_pkg::ST_EMIT: begin
                if (!emit_busy) begin
                    n_state = itoa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itoa_pkg::ST_IDLE;
            end
        endcase
    end

    // Hold the per-item settings
    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_radix <= c_radix;
            r_neg   <= c_neg;
            r_upper <= (c_op == itoa_pkg::OP_RADIX_UPPER);
        end
    end

    itoa_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_divider (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (c_accept),
        .i_operand (c_mag),
        .i_run     (r_state == itoa_pkg::ST_DIV),
        .i_radix   (r_radix),
        .o_stat    (div_stat)
    );

    itoa_emitter #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (emit_ctrl),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_busy     (emit_busy)
    );

endmodule

// ===== hdl/itoa_divider.sv =====
// Digit-serial divider: one pass divides the held value by the radix, a byte per cycle while running.
// The quotient replaces the dividend in place; the remainder is the next digit.
// Depends on itoa_pkg.
module itoa_divider #(
    parameter int VALUE_WIDTH = itoa_pkg::ITOA_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [VALUE_WIDTH-1:0]        i_operand,
    input  logic                          i_run,
    input  logic [itoa_pkg::BASE_W-1:0]   i_radix,
    output itoa_pkg::t_div_stat           o_stat
);

    localparam int S      = itoa_pkg::ITOA_CHUNK;
    localparam int CHUNKS = (VALUE_WIDTH + S - 1) / S;
    localparam int PW     = CHUNKS * S;
    localparam int CNT_W  = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam logic [CNT_W-1:0] LAST_CHUNK = CNT_W'(CHUNKS - 1);
    localparam int BW     = itoa_pkg::BASE_W;
    localparam int DW     = itoa_pkg::DIGIT_W;

    logic [PW-1:0]    r_dvd;
    logic [DW-1:0]    r_rem;
    logic             r_qnz;
    logic [CNT_W-1:0] r_chunk;

    logic [BW-1:0]    c_rem;
    logic [S-1:0]     c_q;
    logic             n_qnz;

    // Restoring division over the top byte of the dividend
    always_comb begin
        c_rem = (r_chunk == '0) ? '0 : BW'(r_rem);
        c_q   = '0;
        for (int i = 0; i < S; i++) begin
            c_rem = {c_rem[BW-2:0], r_dvd[PW-1-i]};
            if (c_rem >= i_radix) begin
                c_rem        = c_rem - i_radix;
                c_q[S-1-i]   = 1'b1;
            end
        end
        n_qnz = ((r_chunk == '0) ? 1'b0 : r_qnz) | (|c_q);
    end

    // Report digit at the end of each pass
    always_comb begin
        o_stat.done  = i_run && (r_chunk == LAST_CHUNK);
        o_stat.qzero = !n_qnz;
        o_stat.digit = c_rem[DW-1:0];
    end

    // Advance the chunk counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_load) begin
            r_chunk <= '0;
        end else if (i_run) begin
            r_chunk <= (r_chunk == LAST_CHUNK) ? '0 : r_chunk + 1'b1;
        end
    end

    // Shift quotient bits in as dividend bits leave
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= PW'(i_operand);
        end else if (i_run) begin
            r_dvd <= PW'({r_dvd, c_q});
            r_rem <= c_rem[DW-1:0];
            r_qnz <= n_qnz;
        end
    end

endmodule

// ===== hdl/itoa_emitter.sv =====
// Digit stack and output stage: collects digits least significant first,
// then sends an optional minus sign and the digits most significant first.
// Depends on itoa_pkg.
module itoa_emitter #(
    parameter int VALUE_WIDTH = itoa_pkg::ITOA_VALUE_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  itoa_pkg::t_emit_ctrl          i_ctrl,
    input  logic                          i_m_tready,
    output logic                          o_m_tvalid,
    output logic [itoa_pkg::CHAR_W-1:0]   o_m_tdata,
    output logic                          o_m_tlast,
    output logic                          o_busy
);

    localparam int DW      = itoa_pkg::DIGIT_W;
    localparam int STACK_W = VALUE_WIDTH * DW;
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);

    logic [STACK_W-1:0]          r_stack;
    logic [CNT_W-1:0]            r_left;
    logic                        r_active;
    logic                        r_sign;
    logic                        r_upper;
    logic                        r_ovalid;
    logic [itoa_pkg::CHAR_W-1:0] r_odata;
    logic                        r_olast;

    logic c_load;
    logic c_final;

    // Load the output register when it is free and a character is pending
    always_comb begin
        c_load  = (!r_ovalid || i_m_tready) && r_active && (r_sign || (r_left != '0));
        c_final = !r_sign && (r_left == CNT_W'(1));
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_active <= 1'b0;
            r_sign   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctrl.start) begin
                r_active <= 1'b1;
                r_sign   <= i_ctrl.negative;
            end else if (c_load) begin
                if (c_final) begin
                    r_active <= 1'b0;
                end
                r_sign <= 1'b0;
            end
            if (i_ctrl.push) begin
                r_left <= r_left + 1'b1;
            end else if (c_load && !r_sign) begin
                r_left <= r_left - 1'b1;
            end
            if (c_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Push digits at the bottom, pop from the bottom, register the beat
    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_upper <= i_ctrl.upper;
        end
        if (i_ctrl.push) begin
            r_stack <= STACK_W'({r_stack, i_ctrl.digit});
        end else if (c_load && !r_sign) begin
            r_stack <= r_stack >> DW;
        end
        if (c_load) begin
            r_odata <= r_sign ? itoa_pkg::CHAR_MINUS
                              : itoa_pkg::digit_char(r_stack[DW-1:0], r_upper);
            r_olast <= c_final;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tlast  = r_olast;
    assign o_busy     = r_active | r_ovalid;

endmodule

// ===== hdl/itoa_checker.sv =====
// Port-level checks for integer_to_ascii_radix, bound to the top level.
// Depends on itoa_pkg and integer_to_ascii_radix_assert.svh.
`include "integer_to_ascii_radix_assert.svh"

module itoa_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [itoa_pkg::CHAR_W-1:0]    o_m_tdata,
    input logic                           o_m_tlast
);

    logic                        c_legal;
    logic                        c_out_stall;
    logic                        c_sign_beat;
    logic                        c_last_beat;
    logic [itoa_pkg::CHAR_W:0]   c_out_beat;

    // Accept only digits, letters a-f or A-F and the minus sign
    always_comb begin
        c_legal = (o_m_tdata == itoa_pkg::CHAR_MINUS);
        for (int d = 0; d < 16; d++) begin
            c_legal = c_legal
                || (o_m_tdata == itoa_pkg::digit_char(itoa_pkg::t_digit'(d), 1'b0))
                || (o_m_tdata == itoa_pkg::digit_char(itoa_pkg::t_digit'(d), 1'b1));
        end
    end

    // Output beat conditions
    always_comb begin
        c_out_stall = o_m_tvalid && !i_m_tready;
        c_sign_beat = o_m_tvalid && (o_m_tdata == itoa_pkg::CHAR_MINUS);
        c_last_beat = o_m_tvalid && i_m_tready && o_m_tlast;
        c_out_beat  = {o_m_tlast, o_m_tdata};
    end

    // A stalled beat holds
    `ITOA_ASSERT_NEXT(a_out_hold, c_out_stall, o_m_tvalid && $stable(c_out_beat), "beat changed")

    // One item in flight: no input taken while characters are pending
    `ITOA_ASSERT_SAME(a_one_item, o_m_tvalid, !o_s_tready, "input ready while output pending")

    // Only digits, letters a-f or A-F and the minus sign leave the block
    `ITOA_ASSERT_SAME(a_char_set, o_m_tvalid, c_legal, "illegal character")

    // A minus sign is always followed by digits
    `ITOA_ASSERT_SAME(a_sign_not_last, c_sign_beat, !o_m_tlast, "minus sign flagged last")

    // Ready returns once the last beat is taken and the output valid and state registers have cleared
    `ITOA_ASSERT_SAME(a_ready_after_last, $past(c_last_beat, 2), o_s_tready, "input not ready")

endmodule

bind integer_to_ascii_radix itoa_checker u_itoa_checker (.*);

// ===== tb/itoa_text_checker.sv =====
// Checker for integer_to_ascii_radix: watches both stream channels, predicts the text
// for every accepted operand beat and compares each output beat. Depends on itoa_pkg.
module itoa_text_checker #(
    parameter int VALUE_WIDTH = itoa_pkg::ITOA_VALUE_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    // [1:0] opcode, [65:2] value, [70:66] base, [71] zero pad
    input  logic [itoa_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    // [7:0] character
    input  logic [itoa_pkg::CHAR_W-1:0]    i_m_tdata,
    input  logic                           i_m_tlast,
    output int                             o_fail_count,
    output int                             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import itoa_pkg::*;

    localparam logic [63:0]       WIDTH_MASK   = {64{1'b1}} >> (64 - VALUE_WIDTH);
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

    typedef struct {
        logic [CHAR_W-1:0] character;
        logic              last;
    } t_text_beat;

    t_text_beat text_q[$];
    int         mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Render one operand beat as text and queue its characters, most significant first
    function automatic void queue_text(input logic [S_TDATA_W-1:0] beat);
        t_opcode           op;
        logic [63:0]       mag;
        logic [63:0]       radix;
        logic [BASE_W-1:0] base;
        logic              negative;
        logic              upper;
        logic [3:0]        dig;
        logic [CHAR_W-1:0] rev[$];
        t_text_beat        tb_beat;

        op       = t_opcode'(beat[OP_W-1:0]);
        mag      = beat[VALUE_LSB +: VALUE_FIELD_W] & WIDTH_MASK;
        base     = beat[BASE_LSB +: BASE_W];
        negative = 1'b0;
        upper    = (op == OP_RADIX_UPPER);

        if (op == OP_SDEC || op == OP_UDEC) begin
            radix = 64'(RADIX_DEC);
            // Form the magnitude in unsigned arithmetic so the most negative value works
            if (op == OP_SDEC && mag[VALUE_WIDTH-1]) begin
                negative = 1'b1;
                mag      = (~mag + 64'd1) & WIDTH_MASK;
            end
        end else begin
            // Clamp the radix to 2..16
            if (base < RADIX_MIN) radix = 64'(RADIX_MIN);
            else if (base > RADIX_MAX) radix = 64'(RADIX_MAX);
            else radix = 64'(base);
        end

        // Collect digits least significant first
        do begin
            dig = 4'(mag % radix);
            if (dig < 4'(RADIX_DEC)) rev.push_back(CHAR_ZERO + CHAR_W'(dig));
            else rev.push_back((upper ? CHAR_UPPER_A : CHAR_LOWER_A) + CHAR_W'(dig) - 8'd10);
            mag = mag / radix;
        end while (mag != 64'd0);

        if (negative) begin
            tb_beat.character = CHAR_MINUS;
            tb_beat.last      = 1'b0;
            text_q.push_back(tb_beat);
        end
        for (int i = rev.size() - 1; i >= 0; i--) begin
            tb_beat.character = rev[i];
            tb_beat.last      = (i == 0);
            text_q.push_back(tb_beat);
        end
    endfunction

    // Predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_text_beat want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                queue_text(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (text_q.size() == 0) begin
                    $error("unexpected beat: character %h last %b", i_m_tdata, i_m_tlast);
                    mismatches++;
                end else begin
                    want = text_q.pop_front();
                    if (i_m_tdata !== want.character) begin
                        $error("character: expected %h, got %h", want.character, i_m_tdata);
                        mismatches++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %b, got %b", want.last, i_m_tlast);
                        mismatches++;
                    end
                end
            end
        end
        o_pending    <= text_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for integer_to_ascii_radix: clock, reset, operand stimulus and verdict.
// Depends on itoa_pkg, the block and itoa_text_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import itoa_pkg::*;

    localparam int RUN_LIMIT     = 4_000_000;
    localparam int DRAIN_CYCLES  = 700;
    localparam int PHASE_ITEMS   = 100;
    localparam int HOLD_CYCLES   = 2500;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [CHAR_W-1:0]      m_tdata;
    logic                   m_tlast;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int rx_hold     = 0;
    int cycle_count = 0;
    int fail_count;
    int pending;

    integer_to_ascii_radix i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    itoa_text_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Bound the run
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_top: done, errors");
        $finish;
    end

    // Drive the output-side ready: long hold-off when asked, else random stalls
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_tready <= 1'b0;
                rx_hold--;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Offer one operand beat, with random idle cycles first; return at a falling edge
    task automatic send_item(input t_opcode op, input logic [63:0] value,
                             input logic [BASE_W-1:0] base);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, base, value, op};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hold the input side until every queued character has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Random operand: random magnitude width, sometimes inverted, mostly legal bases
    task automatic send_random();
        t_opcode           op;
        logic [63:0]       value;
        logic [BASE_W-1:0] base;
        int                w;
        op    = t_opcode'($urandom_range(3));
        w     = $urandom_range(64, 1);
        value = {$urandom, $urandom};
        value = value >> (64 - w);
        if ($urandom_range(3) == 0) value = ~value;
        if ($urandom_range(4) == 0) base = BASE_W'($urandom_range(31));
        else base = BASE_W'($urandom_range(16, 2));
        send_item(op, value, base);
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: zero, extremes, most negative, clamped and ignored bases
        send_item(OP_SDEC, 64'd0, 5'd10);
        send_item(OP_SDEC, 64'd1, 5'd0);
        send_item(OP_SDEC, {64{1'b1}}, 5'd31);
        send_item(OP_SDEC, 64'h8000_0000_0000_0000, 5'd3);
        send_item(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 5'd16);
        send_item(OP_SDEC, -64'sd123456789, 5'd2);
        send_item(OP_UDEC, 64'd0, 5'd31);
        send_item(OP_UDEC, {64{1'b1}}, 5'd2);
        send_item(OP_UDEC, 64'd10000000000000000000, 5'd0);
        send_item(OP_UDEC, 64'h8000_0000_0000_0000, 5'd17);
        send_item(OP_RADIX_LOWER, {64{1'b1}}, 5'd2);
        send_item(OP_RADIX_LOWER, {64{1'b1}}, 5'd16);
        send_item(OP_RADIX_LOWER, 64'd5, 5'd0);
        send_item(OP_RADIX_LOWER, 64'd6, 5'd1);
        send_item(OP_RADIX_LOWER, 64'd255, 5'd17);
        send_item(OP_RADIX_LOWER, 64'hDEAD_BEEF, 5'd31);
        send_item(OP_RADIX_LOWER, 64'h1234_5678_9ABC_DEF0, 5'd7);
        send_item(OP_RADIX_LOWER, 64'h8000_0000_0000_0000, 5'd3);
        send_item(OP_RADIX_UPPER, 64'hDEAD_BEEF_CAFE_F00D, 5'd16);
        send_item(OP_RADIX_UPPER, 64'd0, 5'd2);
        send_item(OP_RADIX_UPPER, 64'hFFFF_FFFF_FFFF_FFFE, 5'd15);
        send_item(OP_RADIX_UPPER, 64'd120, 5'd11);
        send_item(OP_RADIX_UPPER, 64'h5555_AAAA_5555_AAAA, 5'd30);
        wait_drained();

        // Random phases: no idling, sender idle, receiver stalls, both
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1) ? 79 : (phase == 3) ? 23 : 0;
            stall_pct = (phase == 2) ? 79 : (phase == 3) ? 23 : 0;
            // Stall the output while operands keep coming so the input backs up
            if (phase == 0) rx_hold = HOLD_CYCLES;
            repeat (PHASE_ITEMS) send_random();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/itoa_pkg.sv
hdl/itoa_divider.sv
hdl/itoa_emitter.sv
hdl/integer_to_ascii_radix.sv
hdl/itoa_checker.sv
tb/itoa_text_checker.sv
tb/tb_top.sv
